>>> src/assert_macros.svh
// Assertion macros for the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, skipping cycles in reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property at every clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> src/b64dec_pkg.sv
// Package for the base64 stream decoder: constants, job type, sextet map.
// Depends on nothing.
package b64dec_pkg;

  localparam int MAX_ENCODED_LEN = 65536;
  localparam int CNT_W = $clog2(MAX_ENCODED_LEN + 2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENCODED_LEN);

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_TOO_BIG  = 2'd2
  } status_t;

  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  nbytes;
    logic        has_status;
    status_t     status;
  } job_t;

  // Return {valid, sextet}.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= CH_UA && c <= CH_UZ) begin
      r = {1'b1, 6'(c - CH_UA)};
    end else if (c >= CH_LA && c <= CH_LZ) begin
      r = {1'b1, 6'(c - CH_LA + 8'd26)};
    end else if (c >= CH_D0 && c <= CH_D9) begin
      r = {1'b1, 6'(c - CH_D0 + 8'd52)};
    end else if (c == CH_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (c == CH_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

>>> src/b64dec_if.sv
// Valid/ready channel interfaces for encoded characters and decoded results.
// Depends on nothing.
interface b64dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

interface b64dec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_status;
  logic [1:0] status;
  logic       last_res;
  modport source (output valid, data_byte, is_status, status, last_res, input ready);
  modport sink (input valid, data_byte, is_status, status, last_res, output ready);
endinterface

>>> src/b64dec_front.sv
// Front end: accepts characters, tracks quad state and errors, builds jobs.
// Depends on b64dec_pkg.
module b64dec_front import b64dec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       job_valid,
  output job_t       job,
  input  logic       job_ready
);

  logic [1:0]       pos, pos_next;
  logic [17:0]      acc, acc_next;
  logic [1:0]       pad, pad_next;
  logic             pdone, pdone_next;
  logic             bad, bad_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    logic [6:0] sx;
    logic [5:0] sv;
    logic       emit;
    sx = sextet_of(ch);
    sv = 6'd0;
    emit = 1'b0;
    pos_next = pos;
    acc_next = acc;
    pad_next = pad;
    pdone_next = pdone;
    bad_next = bad | pdone;
    cnt_next = (cnt <= MAX_CNT) ? cnt + 1'b1 : cnt;
    job = '0;

    if (ch == CH_PAD) begin
      if (pos < 2'd2) begin
        bad_next = 1'b1;
      end else begin
        pad_next = pad + 2'd1;
      end
    end else begin
      if (!sx[6]) begin
        bad_next = 1'b1;
      end else begin
        sv = sx[5:0];
      end
      if (pad != 2'd0) begin
        bad_next = 1'b1;
      end
    end

    if (pos != 2'd3) begin
      acc_next = {acc[11:0], sv};
      pos_next = pos + 2'd1;
    end else begin
      job.triple = {acc, sv};
      job.nbytes = 2'd3;
      if (pad_next != 2'd0) begin
        pdone_next = 1'b1;
        job.nbytes = (pad_next >= 2'd2) ? 2'd1 : 2'd2;
      end
      emit = !bad_next && (cnt_next <= MAX_CNT);
      if (!emit) begin
        job.nbytes = 2'd0;
      end
      acc_next = '0;
      pad_next = '0;
      pos_next = '0;
    end

    if (last) begin
      job.has_status = 1'b1;
      if (cnt_next > MAX_CNT) begin
        job.status = ST_TOO_BIG;
      end else if (bad_next || pos_next != 2'd0) begin
        job.status = ST_BAD;
      end else begin
        job.status = ST_OK;
      end
      pos_next = '0;
      acc_next = '0;
      pad_next = '0;
      pdone_next = 1'b0;
      bad_next = 1'b0;
      cnt_next = '0;
    end

    job_valid = in_valid && (emit || last);
  end

  assign in_ready = job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      acc <= '0;
      pad <= '0;
      pdone <= 1'b0;
      bad <= 1'b0;
      cnt <= '0;
    end else if (in_valid && in_ready) begin
      pos <= pos_next;
      acc <= acc_next;
      pad <= pad_next;
      pdone <= pdone_next;
      bad <= bad_next;
      cnt <= cnt_next;
    end
  end

endmodule

>>> src/b64dec_queue.sv
// Short job queue between front and back ends.
// Depends on b64dec_pkg.
module b64dec_queue import b64dec_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic not_empty
);

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full = (count == (QAW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/b64dec_back.sv
// Back end: unpacks each job into byte beats and, for a text's last job, the closing status beat.
// Depends on b64dec_pkg.
module b64dec_back import b64dec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_not_empty,
  input  job_t       q_dout,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       is_status,
  output logic [1:0] status,
  output logic       last_res
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] k;
  logic [2:0] nres;
  logic       fire;
  logic       job_end;
  logic       load;

  assign nres = {1'b0, cur.nbytes} + {2'b00, cur.has_status};
  assign fire = cur_valid && out_ready;
  assign job_end = ({1'b0, k} + 3'd1) == nres;
  assign load = !cur_valid || (fire && job_end);
  assign q_pop = load && q_not_empty;

  always_comb begin
    out_valid = cur_valid;
    is_status = (k == cur.nbytes);
    last_res = is_status;
    status = is_status ? cur.status : ST_OK;
    case (k)
      2'd0:    data_byte = cur.triple[23:16];
      2'd1:    data_byte = cur.triple[15:8];
      2'd2:    data_byte = cur.triple[7:0];
      default: data_byte = 8'd0;
    endcase
    if (is_status) begin
      data_byte = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_dout;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k <= '0;
    end else if (load) begin
      cur_valid <= q_not_empty;
      k <= '0;
    end else if (fire) begin
      k <= k + 2'd1;
    end
  end

endmodule

>>> src/base64_stream_decoder_unit.sv
// Base64 stream decoder: one character beat in, byte and status beats out.
// A job is written into the job queue at its accepting edge, then loaded into the back end's current job before
// its first result is offered. Throughput: one character per cycle while the job queue is not full, and one
// result per cycle while results.ready is high; a full 4-entry job queue holds the input.
// Reset (rst, synchronous): clears quad state, error flags, queue, output.
module base64_stream_decoder_unit import b64dec_pkg::*; (
  input  logic clk,
  input  logic rst,
  b64dec_in_if.sink    chars,
  b64dec_out_if.source results
);

  logic job_valid;
  job_t job;
  logic q_full;
  logic q_pop;
  job_t q_dout;
  logic q_not_empty;

  b64dec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .ch        (chars.ch),
    .last      (chars.last),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (!q_full)
  );

  b64dec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid && !q_full),
    .din       (job),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_not_empty)
  );

  b64dec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_dout      (q_dout),
    .q_pop       (q_pop),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .data_byte   (results.data_byte),
    .is_status   (results.is_status),
    .status      (results.status),
    .last_res    (results.last_res)
  );

endmodule

>>> src/b64dec_checker.sv
// Port-level checks for the base64 stream decoder, bound to the top level.
// Depends on assert_macros.svh and b64dec_pkg.
`include "assert_macros.svh"

module b64dec_checker import b64dec_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic       is_status,
  input logic [1:0] status,
  input logic       last_res
);

  `ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid)
  `ASSERT_CLK(a_stall_holds_valid, clk, rst, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_status_is_last, clk, rst, out_valid |-> (is_status == last_res))
  `ASSERT_CLK(a_byte_no_status, clk, rst, out_valid && !is_status |-> status == ST_OK)
  `ASSERT_CLK(a_status_clean, clk, rst,
    out_valid && is_status |-> (data_byte == 8'd0 && status != 2'd3))

endmodule

bind base64_stream_decoder_unit b64dec_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .data_byte (results.data_byte),
  .is_status (results.is_status),
  .status    (results.status),
  .last_res  (results.last_res)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for base64_stream_decoder_unit: directed, random and backpressure texts.
// Predicts every byte and status beat in-line and checks them in order of arrival.
// Depends on b64dec_pkg, the channel interfaces in b64dec_if.sv and the decoder RTL.
module tb import b64dec_pkg::*; ();

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_CHARS = 240;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_status;
    logic [1:0] status;
    logic       last_res;
  } dec_result_t;

  typedef logic [7:0] char_q_t[$];

  logic clk;
  logic rst;

  b64dec_in_if  chars_if ();
  b64dec_out_if res_if ();

  base64_stream_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .results(res_if)
  );

  dec_result_t decoded_q[$];

  logic [1:0]  quad_pos;
  logic [17:0] sextet_acc;
  logic [1:0]  pads_in_quad;
  logic        padded_done;
  logic        text_bad;
  int          text_len;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold_len = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int texts_seen = 0;
  int results_seen = 0;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int char_value(input logic [7:0] c);
    if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA);
    if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 26;
    if (c >= CH_D0 && c <= CH_D9) return int'(c - CH_D0) + 52;
    if (c == CH_PLUS) return 62;
    if (c == CH_SLASH) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < 6'd26) return CH_UA + 8'(v);
    if (v < 6'd52) return CH_LA + 8'(v) - 8'd26;
    if (v < 6'd62) return CH_D0 + 8'(v) - 8'd52;
    if (v == 6'd62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic char_q_t encode_random(input int nbytes);
    char_q_t txt;
    logic [23:0] w;
    int rem;
    for (int i = 0; i < nbytes; i += 3) begin
      rem = (nbytes - i > 3) ? 3 : nbytes - i;
      w = 24'($urandom());
      txt.push_back(alphabet_char(w[23:18]));
      txt.push_back(alphabet_char(w[17:12]));
      txt.push_back(rem >= 2 ? alphabet_char(w[11:6]) : CH_PAD);
      txt.push_back(rem == 3 ? alphabet_char(w[5:0]) : CH_PAD);
    end
    return txt;
  endfunction

  task automatic clear_text_state();
    quad_pos = '0;
    sextet_acc = '0;
    pads_in_quad = '0;
    padded_done = 1'b0;
    text_bad = 1'b0;
    text_len = 0;
  endtask

  task automatic push_result(input logic [7:0] b, input logic is_st, input logic [1:0] st,
                             input logic lr);
    dec_result_t r;
    r.data_byte = b;
    r.is_status = is_st;
    r.status = st;
    r.last_res = lr;
    decoded_q.push_back(r);
  endtask

  task automatic predict_char(input logic [7:0] c, input logic l);
    int v;
    logic [5:0] sx;
    logic [23:0] word;
    int nb;
    status_t st;
    v = char_value(c);
    sx = '0;
    if (text_len <= MAX_ENCODED_LEN) text_len++;
    if (padded_done) text_bad = 1'b1;
    if (c == CH_PAD) begin
      if (quad_pos < 2'd2) text_bad = 1'b1;
      else pads_in_quad = pads_in_quad + 2'd1;
    end else begin
      if (v < 0) text_bad = 1'b1;
      else sx = v[5:0];
      if (pads_in_quad != 2'd0) text_bad = 1'b1;
    end
    if (quad_pos < 2'd3) begin
      sextet_acc = {sextet_acc[11:0], sx};
      quad_pos = quad_pos + 2'd1;
    end else begin
      word = {sextet_acc, sx};
      nb = 3;
      if (pads_in_quad != 2'd0) begin
        padded_done = 1'b1;
        nb = (pads_in_quad >= 2'd2) ? 1 : 2;
      end
      if (!text_bad && text_len <= MAX_ENCODED_LEN) begin
        push_result(word[23:16], 1'b0, ST_OK, 1'b0);
        if (nb >= 2) push_result(word[15:8], 1'b0, ST_OK, 1'b0);
        if (nb >= 3) push_result(word[7:0], 1'b0, ST_OK, 1'b0);
      end
      sextet_acc = '0;
      pads_in_quad = '0;
      quad_pos = '0;
    end
    if (l) begin
      st = ST_OK;
      if (text_len > MAX_ENCODED_LEN) st = ST_TOO_BIG;
      else if (text_bad || quad_pos != 2'd0) st = ST_BAD;
      push_result(8'd0, 1'b1, st, 1'b1);
      texts_seen++;
      clear_text_state();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic l);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch <= c;
    chars_if.last <= l;
    do @(posedge clk); while (chars_if.ready !== 1'b1);
    predict_char(c, l);
    chars_sent++;
  endtask

  task automatic send_queue(input char_q_t txt);
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic test_directed();
    send_text("TQ==");
    send_text("+/9aZ0Q=");
    send_text("AB=C");
    send_text("AB==zA");
    send_char(8'hFF, 1'b1);
    send_char(CH_PAD, 1'b1);
  endtask

  task automatic test_backpressure();
    // hold the output while the input keeps offering full quads
    tx_idle_on = 1'b0;
    rx_hold_len = HOLD_CYCLES;
    send_queue(encode_random(30));
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_texts();
    char_q_t txt;
    int kind;
    int pos;
    int start;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      if ($urandom_range(0, 5) == 0) tx_idle_on = !tx_idle_on;
      if ($urandom_range(0, 5) == 0) rx_idle_on = !rx_idle_on;
      kind = $urandom_range(0, 9);
      txt.delete();
      if (kind < 8) begin
        txt = encode_random($urandom_range(1, 12));
        if (kind >= 6) begin
          pos = $urandom_range(0, txt.size() - 1);
          case ($urandom_range(0, 3))
            0: txt[pos] = 8'($urandom_range(0, 255));
            1: if (txt.size() > 1) txt.delete(pos);
            2: txt.insert(pos, CH_PAD);
            default: repeat (4) txt.push_back(alphabet_char(6'($urandom_range(0, 63))));
          endcase
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 9)) txt.push_back(alphabet_char(6'($urandom_range(0, 63))));
      end
      send_queue(txt);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : receiver
    int rx_wait;
    rx_wait = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        rx_wait = rx_hold_len;
        rx_hold_len = 0;
      end
      if (rst || rx_wait > 0) begin
        res_if.ready <= 1'b0;
        if (rx_wait > 0) rx_wait--;
      end else begin
        res_if.ready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    dec_result_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual data_byte %0h is_status %0b",
                 $time, res_if.data_byte, res_if.is_status);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("data_byte", want.data_byte, res_if.data_byte);
        check_field("is_status", 8'(want.is_status), 8'(res_if.is_status));
        check_field("status", 8'(want.status), 8'(res_if.status));
        check_field("last_res", 8'(want.last_res), 8'(res_if.last_res));
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d beats outstanding", cycles, decoded_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    chars_if.valid <= 1'b0;
    chars_if.ch <= 8'd0;
    chars_if.last <= 1'b0;
    clear_text_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_texts();
    chars_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $display("%0d expected beats never arrived", decoded_q.size());
      fail_count++;
    end
    $display("Sent %0d texts, %0d characters: padding and error cases, a long output stall,",
             texts_seen, chars_sent);
    $display("and random texts with stray characters; %0d result beats checked, %0d mismatches.",
             results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
